[sv/ulfp_pkg.sv]
// shared types, character codes and helper functions of the uri-list path extractor
package ulfp_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int MAX_RES = 4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] SCHEME_LEN = 4'd7;
  localparam logic [3:0] HOST_LEN   = 4'd9;
  localparam logic [3:0] AUTH_SAT   = 4'd10;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_AUTH   = 2'd1,
    PH_PATH   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       done;
  } res_t;

  typedef struct packed {
    logic [2:0]         cnt;
    res_t [MAX_RES-1:0] ent;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] scheme_char(logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6C;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h3A;
      3'd5:    ch = 8'h2F;
      3'd6:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] host_char(logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0:    ch = 8'h6C;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h6C;
      4'd5:    ch = 8'h68;
      4'd6:    ch = 8'h6F;
      4'd7:    ch = 8'h73;
      4'd8:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic hex_t hex_of(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

  function automatic bundle_t bundle_put(bundle_t bi, logic [7:0] b, logic done);
    bundle_t bo;
    bo = bi;
    if (bi.cnt < 3'(MAX_RES)) begin
      bo.ent[bi.cnt[1:0]].b    = b;
      bo.ent[bi.cnt[1:0]].done = done;
      bo.cnt                   = bi.cnt + 3'd1;
    end
    return bo;
  endfunction

  function automatic bundle_t esc_flush(bundle_t bi, logic [1:0] cnt, logic [7:0] ch);
    bundle_t bo;
    bo = bi;
    if (cnt >= 2'd1) bo = bundle_put(bo, CH_PCT, 1'b0);
    if (cnt >= 2'd2) bo = bundle_put(bo, ch, 1'b0);
    return bo;
  endfunction

endpackage

[sv/ulfp_front.sv]
// front end: line parser and escape decoder, turns one byte into a bundle of results
module ulfp_front import ulfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_text_byte,
  input  logic       in_payload_end,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_bundle
);

  phase_t     ph_r,  ph_nxt;
  logic [3:0] mp_r,  mp_nxt;
  logic       am_r,  am_nxt;
  logic [1:0] ec_r,  ec_nxt;
  logic [7:0] eh_r,  eh_nxt;
  logic       rh_r,  rh_nxt;
  bundle_t    bnd;
  logic       accept;
  logic       lf;
  logic       consumed;
  hex_t       hv;
  hex_t       hh;

  assign accept = in_push && !q_full;
  assign lf     = (in_text_byte == CH_LF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_PREFIX;
      mp_r <= 4'd0;
      am_r <= 1'b1;
      ec_r <= 2'd0;
      eh_r <= 8'd0;
      rh_r <= 1'b0;
    end else if (accept) begin
      ph_r <= ph_nxt;
      mp_r <= mp_nxt;
      am_r <= am_nxt;
      ec_r <= ec_nxt;
      eh_r <= eh_nxt;
      rh_r <= rh_nxt;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    mp_nxt   = mp_r;
    am_nxt   = am_r;
    ec_nxt   = ec_r;
    eh_nxt   = eh_r;
    rh_nxt   = rh_r;
    bnd      = '0;
    consumed = 1'b0;
    hv       = hex_of(in_text_byte);
    hh       = hex_of(eh_r);
    if (!lf) begin
      case (ph_r)
        PH_PREFIX: begin
          if (mp_r < SCHEME_LEN && in_text_byte == scheme_char(mp_r[2:0])) begin
            mp_nxt = mp_r + 4'd1;
            if (mp_nxt == SCHEME_LEN) begin
              ph_nxt = PH_AUTH;
              mp_nxt = 4'd0;
              am_nxt = 1'b1;
            end
          end else begin
            ph_nxt = PH_SKIP;
          end
        end
        PH_AUTH: begin
          if (in_text_byte == CH_SLASH) begin
            if (mp_r == 4'd0 || (am_r && mp_r == HOST_LEN)) begin
              ph_nxt = PH_PATH;
              bnd    = bundle_put(bnd, CH_SLASH, 1'b0);
            end else begin
              ph_nxt = PH_SKIP;
            end
          end else begin
            if (mp_r >= HOST_LEN || in_text_byte != host_char(mp_r)) am_nxt = 1'b0;
            if (mp_r < AUTH_SAT) mp_nxt = mp_r + 4'd1;
          end
        end
        PH_PATH: begin
          if (rh_r) begin
            bnd    = bundle_put(bnd, CH_CR, 1'b0);
            rh_nxt = 1'b0;
          end
          if (in_text_byte == CH_CR) begin
            bnd    = esc_flush(bnd, ec_nxt, eh_nxt);
            ec_nxt = 2'd0;
            eh_nxt = 8'd0;
            rh_nxt = 1'b1;
          end else begin
            if (ec_r == 2'd1) begin
              if (hv.ok) begin
                eh_nxt   = in_text_byte;
                ec_nxt   = 2'd2;
                consumed = 1'b1;
              end else begin
                bnd    = esc_flush(bnd, ec_r, eh_r);
                ec_nxt = 2'd0;
                eh_nxt = 8'd0;
              end
            end else if (ec_r >= 2'd2) begin
              if (hv.ok) begin
                bnd      = bundle_put(bnd, {(hh.ok ? hh.val : 4'd0), hv.val}, 1'b0);
                ec_nxt   = 2'd0;
                eh_nxt   = 8'd0;
                consumed = 1'b1;
              end else begin
                bnd    = esc_flush(bnd, ec_r, eh_r);
                ec_nxt = 2'd0;
                eh_nxt = 8'd0;
              end
            end
            if (!consumed) begin
              if (in_text_byte == CH_PCT) ec_nxt = 2'd1;
              else bnd = bundle_put(bnd, in_text_byte, 1'b0);
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (lf || in_payload_end) begin
      if (ph_nxt == PH_PATH) begin
        bnd = esc_flush(bnd, ec_nxt, eh_nxt);
        bnd = bundle_put(bnd, 8'd0, 1'b1);
      end
      ph_nxt = PH_PREFIX;
      mp_nxt = 4'd0;
      am_nxt = 1'b1;
      ec_nxt = 2'd0;
      eh_nxt = 8'd0;
      rh_nxt = 1'b0;
    end
  end

  assign q_push   = accept && (bnd.cnt != 3'd0);
  assign q_bundle = bnd;

  a_esc_only_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (ec_r != 2'd0 || rh_r) |-> (ph_r == PH_PATH))
    else $error("escape or return held outside a path");
  a_cr_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    rh_r |-> (ec_r == 2'd0))
    else $error("escape held together with a carriage return");

endmodule

[sv/ulfp_queue.sv]
// short bundle queue between the parser and the result serialiser
module ulfp_queue import ulfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    deq,
  output logic    full,
  output logic    empty,
  output bundle_t head
);

  bundle_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r,    cnt_nxt;
  logic            do_deq;

  assign full   = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_deq = deq && !empty;
  assign head   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? Q_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_deq ? Q_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_bundle;
  end

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (head.cnt != 3'd0 && head.cnt <= 3'(MAX_RES)))
    else $error("queued bundle has no results");

endmodule

[sv/ulfp_back.sv]
// back end: hands out the results of the head bundle one item at a time
module ulfp_back import ulfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  bundle_t    q_head,
  output logic       q_deq,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_path_byte,
  output logic       out_path_done,
  output logic       out_run_last
);

  logic [1:0] pos_r, pos_nxt;
  logic       last_ent;
  logic       take;

  assign out_empty     = q_empty;
  assign take          = out_pop && !q_empty;
  assign last_ent      = (({1'b0, pos_r} + 3'd1) == q_head.cnt);
  assign out_path_byte = q_head.ent[pos_r].b;
  assign out_path_done = q_head.ent[pos_r].done;
  assign out_run_last  = last_ent;
  assign q_deq         = take && last_ent;

  always_comb begin
    pos_nxt = pos_r;
    if (take) pos_nxt = last_ent ? 2'd0 : pos_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= 2'd0;
    else        pos_r <= pos_nxt;
  end

  a_pos_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ({1'b0, pos_r} < q_head.cnt))
    else $error("result position beyond bundle");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_path_done) |-> (out_run_last && out_path_byte == 8'd0))
    else $error("end-of-path marker not last or not zero");

endmodule

[sv/uri_list_file_path_extractor_top.sv]
// top level of the uri-list file path extractor
// Takes one payload byte per cycle and keeps that rate while each byte gives at most one
// result and the receiver keeps popping; a byte that gives k results (up to four, at line
// ends, failed escapes or after a CR) holds the result side for k pops. Results of a byte
// travel as one bundle through a four-entry queue between the parser and the serialiser,
// so bursts are absorbed and the input stalls (full) only once four bundles wait.
module uri_list_file_path_extractor_top import ulfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_byte,
  input  logic       in_payload_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_path_byte,
  output logic       out_path_done,
  output logic       out_run_last
);

  logic    q_push;
  logic    q_full;
  logic    q_empty;
  logic    q_deq;
  bundle_t q_bundle;
  bundle_t q_head;

  assign in_full = q_full;

  ulfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_text_byte   (in_text_byte),
    .in_payload_end (in_payload_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_bundle       (q_bundle)
  );

  ulfp_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_bundle (q_bundle),
    .deq         (q_deq),
    .full        (q_full),
    .empty       (q_empty),
    .head        (q_head)
  );

  ulfp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_deq         (q_deq),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_path_byte (out_path_byte),
    .out_path_done (out_path_done),
    .out_run_last  (out_run_last)
  );

endmodule

[bench/tb_top.sv]
// self-checking bench for the uri-list file path extractor: directed lines, random payloads, stalls
module tb_top import ulfp_pkg::*;;

  localparam logic [55:0] SCHEME_TXT = "file://";
  localparam logic [71:0] HOST_TXT   = "localhost";
  localparam logic [7:0]  CH_HASH    = 8'h23;
  localparam int          LIMIT_TU   = 2_000_000;

  typedef struct packed {
    logic [7:0] b;
    logic       done;
    logic       last;
  } path_item_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_push        = 1'b0;
  logic       in_full;
  logic [7:0] in_text_byte   = 8'h00;
  logic       in_payload_end = 1'b0;
  logic       out_empty;
  logic       out_pop        = 1'b0;
  logic [7:0] out_path_byte;
  logic       out_path_done;
  logic       out_run_last;

  path_item_t path_q[$];
  path_item_t step_buf[$];
  logic [7:0] line_buf[$];

  phase_t     ln_phase;
  logic [3:0] ln_pos;
  logic       ln_host_ok;
  logic [1:0] esc_n;
  logic [7:0] esc_c;
  logic       cr_wait;

  int err_count   = 0;
  int hold_cycles = 0;
  int burst_left  = 0;
  int sent_count  = 0;
  bit pop_random  = 1'b1;
  bit gaps_on     = 1'b1;

  uri_list_file_path_extractor_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_text_byte   (in_text_byte),
    .in_payload_end (in_payload_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_path_byte  (out_path_byte),
    .out_path_done  (out_path_done),
    .out_run_last   (out_run_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_TU);
    $display("tb_top NOT OK");
    $finish;
  end

  // path prediction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic void emit(logic [7:0] b, logic done);
    path_item_t r;
    r.b    = b;
    r.done = done;
    r.last = 1'b0;
    if (step_buf.size() < MAX_RES) step_buf = {step_buf, r};
  endfunction

  function automatic void flush_esc();
    if (esc_n >= 2'd1) emit(CH_PCT, 1'b0);
    if (esc_n >= 2'd2) emit(esc_c, 1'b0);
    esc_n = 2'd0;
    esc_c = 8'h00;
  endfunction

  function automatic void line_clear();
    ln_phase   = PH_PREFIX;
    ln_pos     = 4'd0;
    ln_host_ok = 1'b1;
    esc_n      = 2'd0;
    esc_c      = 8'h00;
    cr_wait    = 1'b0;
  endfunction

  function automatic void path_char(logic [7:0] c);
    logic [4:0] lo;
    logic [4:0] hi;
    bit         taken;
    lo    = hex_digit(c);
    hi    = hex_digit(esc_c);
    taken = 1'b0;
    if (esc_n == 2'd1) begin
      if (lo[4]) begin
        esc_c = c;
        esc_n = 2'd2;
        taken = 1'b1;
      end else begin
        flush_esc();
      end
    end else if (esc_n == 2'd2) begin
      if (lo[4]) begin
        emit({hi[3:0], lo[3:0]}, 1'b0);
        esc_n = 2'd0;
        esc_c = 8'h00;
        taken = 1'b1;
      end else begin
        flush_esc();
      end
    end
    if (!taken) begin
      if (c == CH_PCT) esc_n = 2'd1;
      else emit(c, 1'b0);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic fin);
    logic       lf;
    path_item_t r;
    lf = (c == CH_LF);
    step_buf.delete();
    if (!lf) begin
      case (ln_phase)
        PH_PREFIX: begin
          if (c == SCHEME_TXT[8*(6-int'(ln_pos)) +: 8]) begin
            ln_pos = ln_pos + 4'd1;
            if (ln_pos == SCHEME_LEN) begin
              ln_phase   = PH_AUTH;
              ln_pos     = 4'd0;
              ln_host_ok = 1'b1;
            end
          end else begin
            ln_phase = PH_SKIP;
          end
        end
        PH_AUTH: begin
          if (c == CH_SLASH) begin
            if (ln_pos == 4'd0 || (ln_host_ok && ln_pos == HOST_LEN)) begin
              ln_phase = PH_PATH;
              emit(CH_SLASH, 1'b0);
            end else begin
              ln_phase = PH_SKIP;
            end
          end else begin
            if (ln_pos >= HOST_LEN) ln_host_ok = 1'b0;
            else if (c != HOST_TXT[8*(8-int'(ln_pos)) +: 8]) ln_host_ok = 1'b0;
            if (ln_pos < AUTH_SAT) ln_pos = ln_pos + 4'd1;
          end
        end
        PH_PATH: begin
          if (cr_wait) begin
            emit(CH_CR, 1'b0);
            cr_wait = 1'b0;
          end
          if (c == CH_CR) begin
            flush_esc();
            cr_wait = 1'b1;
          end else begin
            path_char(c);
          end
        end
        default: ;
      endcase
    end
    if (lf || fin) begin
      if (ln_phase == PH_PATH) begin
        flush_esc();
        emit(8'h00, 1'b1);
      end
      line_clear();
    end
    if (step_buf.size() > 0) begin
      r      = step_buf[step_buf.size() - 1];
      r.last = 1'b1;
      step_buf[step_buf.size() - 1] = r;
    end
    foreach (step_buf[i]) path_q = {path_q, step_buf[i]};
  endfunction

  // checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (err_count < 30) $display("%0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    path_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (path_q.size() == 0) begin
        report_mismatch("unexpected result, path_byte", out_path_byte, 8'h00);
      end else begin
        want = path_q.pop_front();
        if (out_path_byte !== want.b) report_mismatch("path_byte", out_path_byte, want.b);
        if (out_path_done !== want.done)
          report_mismatch("path_done", 8'(out_path_done), 8'(want.done));
        if (out_run_last !== want.last)
          report_mismatch("run_last", 8'(out_run_last), 8'(want.last));
      end
    end
  end

  // receiver with its own stall pattern and a counted hold-off

  initial begin : receiver
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        hold_cycles--;
      end else if (!pop_random) begin
        out_pop <= 1'b1;
      end else if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_pop <= 1'b1;
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 12);
        stall_left = $urandom_range(0, 6);
        out_pop <= 1'b1;
      end
    end
  end

  // sender

  task automatic send_byte(logic [7:0] c, logic fin);
    if (gaps_on && burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_push        <= 1'b1;
    in_text_byte   <= c;
    in_payload_end <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_byte(c, fin);
    sent_count++;
  endtask

  function automatic void add_byte(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_buf(bit fin, bit scatter);
    logic [7:0] c;
    bit         e;
    while (line_buf.size() > 0) begin
      c = line_buf.pop_front();
      e = (fin && line_buf.size() == 0) || (scatter && $urandom_range(0, 59) == 0);
      send_byte(c, e);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte_no_lf();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] rand_no_hex();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = rand_byte_no_lf();
      h = hex_digit(c);
    end while (h[4]);
    return c;
  endfunction

  // tests

  task automatic test_decode();
    put_text("file:///a%41%4a%4F%7e%00/b%FF%fF%c3%A9\n");
    send_buf(1'b0, 1'b0);
  endtask

  task automatic test_authority();
    put_text("file://localhost/x\n");
    put_text("file://host/y\n");
    put_text("file://localhostx/z\n");
    put_text("file://localhostlocalhost/q\n");
    put_text("file://localhos/w\n");
    put_text("file://abc\n");
    put_text("FILE:///a\n");
    put_text("file:/x\n");
    send_buf(1'b0, 1'b0);
  endtask

  task automatic test_line_ends();
    put_text("\n#file:///c\nfile:///r\015\nfile:///m\015\015\n\015\n");
    send_buf(1'b0, 1'b0);
  endtask

  task automatic test_escape_failures();
    put_text("file:///%g%4%%41%\n");
    send_buf(1'b0, 1'b0);
    put_text("file:///%4z");
    send_buf(1'b1, 1'b0);
    put_text("file:///%");
    send_buf(1'b1, 1'b0);
  endtask

  task automatic test_cr_in_path();
    put_text("file:///a\015b%4\015c%\015d%41\015\n");
    send_buf(1'b0, 1'b0);
  endtask

  task automatic test_payload_end();
    put_text("file:///end");
    send_buf(1'b1, 1'b0);
    put_text("file:///e\n");
    send_buf(1'b1, 1'b0);
    put_text("file:///c\015");
    send_buf(1'b1, 1'b0);
    put_text("file://");
    send_buf(1'b1, 1'b0);
    put_text("file:///");
    send_buf(1'b1, 1'b0);
    put_text("fi");
    send_buf(1'b1, 1'b0);
    put_text("file:///after\n");
    send_buf(1'b0, 1'b0);
  endtask

  task automatic test_extreme_bytes();
    put_text("file:///");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h7F);
    add_byte(CH_LF);
    send_buf(1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    pop_random  = 1'b0;
    gaps_on     = 1'b0;
    hold_cycles = 120;
    put_text("file:///");
    repeat (40) add_byte(8'($urandom_range(8'h30, 8'h7a)));
    add_byte(CH_LF);
    send_buf(1'b0, 1'b0);
    wait_drained();
    pop_random = 1'b1;
    gaps_on    = 1'b1;
  endtask

  task automatic send_random_line();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6 || kind == 8) begin
      put_text("file://");
      if (kind == 8) line_buf[$urandom_range(0, 6)] = rand_byte_no_lf();
      case ($urandom_range(0, 5))
        0, 1, 2: ;
        3: put_text("localhost");
        4: begin
          put_text("localhost");
          line_buf[line_buf.size() - 1 - $urandom_range(0, 8)] = rand_byte_no_lf();
        end
        default: begin
          repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(8'h61, 8'h7a)));
        end
      endcase
      if ($urandom_range(0, 9) != 0) add_byte(CH_SLASH);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: add_byte(8'($urandom_range(8'h20, 8'h7e)));
          4, 5: begin
            add_byte(CH_PCT);
            add_byte(rand_hex());
            add_byte(rand_hex());
          end
          6: begin
            add_byte(CH_PCT);
            if ($urandom_range(0, 1) != 0) add_byte(rand_hex());
            add_byte(rand_no_hex());
          end
          7: add_byte(CH_CR);
          default: add_byte(rand_byte_no_lf());
        endcase
      end
    end else if (kind == 7) begin
      add_byte(CH_HASH);
      repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(8'h20, 8'h7e)));
    end else begin
      repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        add_byte(CH_LF);
        send_buf(1'b0, 1'b1);
      end
      6, 7: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_buf(1'b0, 1'b1);
      end
      8: begin
        add_byte(CH_CR);
        send_buf(1'b1, 1'b1);
      end
      default: begin
        if (line_buf.size() == 0) add_byte(CH_LF);
        send_buf(1'b1, 1'b1);
      end
    endcase
  endtask

  task automatic test_random_payloads(int n_bytes, bit idle);
    int start;
    start      = sent_count;
    gaps_on    = idle;
    pop_random = idle;
    while (sent_count - start < n_bytes) send_random_line();
    gaps_on    = 1'b1;
    pop_random = 1'b1;
  endtask

  initial begin
    line_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_decode();
    test_authority();
    test_line_ends();
    test_escape_failures();
    test_cr_in_path();
    test_payload_end();
    test_extreme_bytes();
    test_backpressure();
    test_random_payloads(20, 1'b0);
    test_random_payloads(40, 1'b1);
    wait_drained();
    if (err_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
